/* design/pmos_pkg.sv */
// ----------------------------------------------------------------------------
// pmos_pkg
// Shared types, constants and helpers for the map point occupancy statistics
// block.
// ----------------------------------------------------------------------------
package pmos_pkg;

    localparam int COUNT_BITS = 32;
    localparam int COORD_BITS = 32;
    localparam int VALUE_BITS = 16;
    localparam int TOTAL_BITS = 32;
    localparam int CFG_BITS   = 32;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic        [COUNT_BITS-1:0] t_count;
    typedef logic        [TOTAL_BITS-1:0] t_total;
    typedef logic        [CFG_BITS-1:0]   t_cfg_data;

    // Q4.12 thresholds: 0.6, 0.4 and the +/-0.19 band
    localparam t_value THRESH_OCCUPIED = 16'sd2458;
    localparam t_value THRESH_FREE     = 16'sd1638;
    localparam t_value BAND_HIGH       = 16'sd778;
    localparam t_value BAND_LOW        = -16'sd778;

    typedef enum logic [2:0] {
        CFG_BOX_ENABLE  = 3'd0,
        CFG_SOURCE_MODE = 3'd1,
        CFG_BOX_X_LOW   = 3'd2,
        CFG_BOX_X_HIGH  = 3'd3,
        CFG_BOX_Y_LOW   = 3'd4,
        CFG_BOX_Y_HIGH  = 3'd5,
        CFG_BOX_Z_LOW   = 3'd6,
        CFG_BOX_Z_HIGH  = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        MODE_OCTREE = 1'b0,
        MODE_CLOUD  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_FREE   = 2'd1,
        CLS_OCC    = 2'd2,
        CLS_UNSEEN = 2'd3
    } t_class;

    // one classified point between the input register and the accumulators
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_class cls;
        logic   first;
        logic   last;
    } t_stage;

    typedef struct packed {
        t_total free_total;
        t_total occupied_total;
        t_total unseen_total;
        t_coord min_x;
        t_coord max_x;
        t_coord min_y;
        t_coord max_y;
        t_coord min_z;
        t_coord max_z;
    } t_stats;

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic t_total report_count(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[TOTAL_BITS-1:0];
    endfunction

endpackage

/* design/pmos_point_if.sv */
// ----------------------------------------------------------------------------
// pmos_point_if
// Point channel: one map point per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmos_point_if;
    import pmos_pkg::*;

    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;
    t_value point_value;
    logic   first_point;
    logic   last_point;

    modport source (
        output valid, point_x, point_y, point_z, point_value, first_point, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, point_value, first_point, last_point,
        output ready
    );
endinterface

/* design/pmos_stats_if.sv */
// ----------------------------------------------------------------------------
// pmos_stats_if
// Statistics channel: counts and axis limits, one beat per finished map.
// ----------------------------------------------------------------------------
interface pmos_stats_if;
    import pmos_pkg::*;

    logic   valid;
    logic   ready;
    t_total free_total;
    t_total occupied_total;
    t_total unseen_total;
    t_coord min_x;
    t_coord max_x;
    t_coord min_y;
    t_coord max_y;
    t_coord min_z;
    t_coord max_z;

    modport source (
        output valid, free_total, occupied_total, unseen_total,
               min_x, max_x, min_y, max_y, min_z, max_z,
        input  ready
    );
    modport sink (
        input  valid, free_total, occupied_total, unseen_total,
               min_x, max_x, min_y, max_y, min_z, max_z,
        output ready
    );
endinterface

/* design/pmos_classify.sv */
// ----------------------------------------------------------------------------
// pmos_classify
// Config registers, box test and value classification; result held in the
// input stage register.
// ----------------------------------------------------------------------------
module pmos_classify (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  pmos_pkg::t_cfg_idx  i_cfg_idx,
    input  pmos_pkg::t_cfg_data i_cfg_data,
    pmos_point_if.sink          i_pt,
    output logic                o_valid,
    input  logic                i_ready,
    output pmos_pkg::t_stage    o_stage
);
    import pmos_pkg::*;

    logic   r_box_en;
    t_mode  r_mode;
    t_coord r_xl, r_xh, r_yl, r_yh, r_zl, r_zh;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;
    logic   n_inside;
    logic   pt_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_en <= 1'b0;
            r_mode   <= MODE_OCTREE;
            r_xl     <= '0;
            r_xh     <= '0;
            r_yl     <= '0;
            r_yh     <= '0;
            r_zl     <= '0;
            r_zh     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_ENABLE:  r_box_en <= i_cfg_data[0];
                CFG_SOURCE_MODE: r_mode   <= t_mode'(i_cfg_data[0]);
                CFG_BOX_X_LOW:   r_xl     <= i_cfg_data;
                CFG_BOX_X_HIGH:  r_xh     <= i_cfg_data;
                CFG_BOX_Y_LOW:   r_yl     <= i_cfg_data;
                CFG_BOX_Y_HIGH:  r_yh     <= i_cfg_data;
                CFG_BOX_Z_LOW:   r_zl     <= i_cfg_data;
                CFG_BOX_Z_HIGH:  r_zh     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_pt.ready = !r_valid || i_ready;
    assign pt_fire    = i_pt.valid && i_pt.ready;

    always_comb begin
        n_inside = !r_box_en ||
                   (i_pt.point_x >= r_xl && i_pt.point_x <= r_xh &&
                    i_pt.point_y >= r_yl && i_pt.point_y <= r_yh &&
                    i_pt.point_z >= r_zl && i_pt.point_z <= r_zh);

        n_stage.x     = i_pt.point_x;
        n_stage.y     = i_pt.point_y;
        n_stage.z     = i_pt.point_z;
        n_stage.first = i_pt.first_point;
        n_stage.last  = i_pt.last_point;
        n_stage.cls   = CLS_NONE;
        if (n_inside) begin
            if (r_mode == MODE_OCTREE) begin
                if (i_pt.point_value >= THRESH_OCCUPIED) begin
                    n_stage.cls = CLS_OCC;
                end else if (i_pt.point_value <= THRESH_FREE) begin
                    n_stage.cls = CLS_FREE;
                end else begin
                    n_stage.cls = CLS_UNSEEN;
                end
            end else begin
                if (i_pt.point_value >= BAND_LOW && i_pt.point_value <= BAND_HIGH) begin
                    n_stage.cls = CLS_OCC;
                end else if (i_pt.point_value > BAND_HIGH) begin
                    n_stage.cls = CLS_FREE;
                end
                // below the band: not counted
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pt.ready) begin
            r_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_fire) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> r_valid)
        else $error("point channel stalled with an empty stage");

    a_open_octree_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_fire && !r_box_en && r_mode == MODE_OCTREE |=> r_stage.cls != CLS_NONE)
        else $error("octree point dropped with box disabled");

    a_held_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_stage))
        else $error("stage beat lost while downstream stalled");

endmodule

/* design/pmos_accum.sv */
// ----------------------------------------------------------------------------
// pmos_accum
// Saturating class counters, per-axis limits and the statistics output
// register.
// ----------------------------------------------------------------------------
module pmos_accum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pmos_pkg::t_stage i_stage,
    pmos_stats_if.source     o_st
);
    import pmos_pkg::*;

    t_count r_free, r_occ, r_unseen;
    t_count n_free, n_occ, n_unseen;
    t_coord r_lo [3];
    t_coord r_hi [3];
    t_coord n_lo [3];
    t_coord n_hi [3];
    t_coord p    [3];

    logic   r_ovalid;
    t_stats r_out;
    logic   s_fire;

    // only a last beat needs room in the output register
    assign o_ready = !i_stage.last || !r_ovalid || o_st.ready;
    assign s_fire  = i_valid && o_ready;

    always_comb begin
        p[0] = i_stage.x;
        p[1] = i_stage.y;
        p[2] = i_stage.z;

        n_free   = r_free;
        n_occ    = r_occ;
        n_unseen = r_unseen;
        n_lo     = r_lo;
        n_hi     = r_hi;

        if (i_stage.first) begin
            n_free   = '0;
            n_occ    = '0;
            n_unseen = '0;
            n_lo     = p;
            n_hi     = p;
        end

        for (int i = 0; i < 3; i++) begin
            if (p[i] < n_lo[i]) begin
                n_lo[i] = p[i];
            end
            if (p[i] > n_hi[i]) begin
                n_hi[i] = p[i];
            end
        end

        case (i_stage.cls)
            CLS_FREE:   n_free   = sat_inc(n_free);
            CLS_OCC:    n_occ    = sat_inc(n_occ);
            CLS_UNSEEN: n_unseen = sat_inc(n_unseen);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free   <= '0;
            r_occ    <= '0;
            r_unseen <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
            end
        end else if (s_fire) begin
            r_free   <= n_free;
            r_occ    <= n_occ;
            r_unseen <= n_unseen;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s_fire && i_stage.last) begin
            r_ovalid <= 1'b1;
        end else if (o_st.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && i_stage.last) begin
            r_out.free_total     <= report_count(n_free);
            r_out.occupied_total <= report_count(n_occ);
            r_out.unseen_total   <= report_count(n_unseen);
            r_out.min_x          <= n_lo[0];
            r_out.max_x          <= n_hi[0];
            r_out.min_y          <= n_lo[1];
            r_out.max_y          <= n_hi[1];
            r_out.min_z          <= n_lo[2];
            r_out.max_z          <= n_hi[2];
        end
    end

    assign o_st.valid          = r_ovalid;
    assign o_st.free_total     = r_out.free_total;
    assign o_st.occupied_total = r_out.occupied_total;
    assign o_st.unseen_total   = r_out.unseen_total;
    assign o_st.min_x          = r_out.min_x;
    assign o_st.max_x          = r_out.max_x;
    assign o_st.min_y          = r_out.min_y;
    assign o_st.max_y          = r_out.max_y;
    assign o_st.min_z          = r_out.min_z;
    assign o_st.max_z          = r_out.max_z;

    a_last_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && i_stage.last |=> o_st.valid)
        else $error("last point produced no statistics beat");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && !i_stage.first |=> r_free >= $past(r_free) && r_occ >= $past(r_occ) &&
                                     r_unseen >= $past(r_unseen))
        else $error("counter went down without a first point");

    a_limits_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo[0] <= r_hi[0] && r_lo[1] <= r_hi[1] && r_lo[2] <= r_hi[2])
        else $error("axis minimum above maximum");

endmodule

/* design/point_map_occupancy_statistics.sv */
// ----------------------------------------------------------------------------
// point_map_occupancy_statistics
// Streams map points, tracks per-axis limits and counts free, occupied and
// unseen points inside a configurable box.
//
// Usage:
//   i_pt carries one point per beat (Q16.16 coordinates, Q4.12 value and the
//   first/last flags). A beat with first_point restarts counts and limits; a
//   beat with last_point makes one beat on o_st with the saturated totals and
//   the axis limits after that point.
//   Config is a write-only port (i_cfg_we, i_cfg_idx, i_cfg_data); write it
//   only while no point is in flight.
//   Throughput: one point per cycle, except while a last point waits on a
//   pending o_st beat. The o_st beat for the last point passes through the
//   input stage register, then the statistics register.
//   Reset clears config, counters and limits to zero; no beat is pending.
//   When o_st stalls, points without last_point keep flowing; a second last
//   point waits in the input stage until the pending beat is taken.
// ----------------------------------------------------------------------------
module point_map_occupancy_statistics (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  pmos_pkg::t_cfg_idx  i_cfg_idx,
    input  pmos_pkg::t_cfg_data i_cfg_data,
    pmos_point_if.sink          i_pt,
    pmos_stats_if.source        o_st
);
    import pmos_pkg::*;

    logic   stage_valid;
    logic   stage_ready;
    t_stage stage;

    pmos_classify u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (i_pt),
        .o_valid    (stage_valid),
        .i_ready    (stage_ready),
        .o_stage    (stage)
    );

    pmos_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .o_ready (stage_ready),
        .i_stage (stage),
        .o_st    (o_st)
    );

endmodule

/* dv/point_map_occupancy_statistics_test.sv */
// ----------------------------------------------------------------------------
// point_map_occupancy_statistics_test
// Self-checking bench for the map point statistics block. A local predictor
// tracks counts, axis limits and the box/mode settings. It forms the expected
// statistics beat for every last point. A monitor compares each o_st beat
// field by field. Directed maps hit the thresholds, the box edges and the
// reset limits. Random maps run under input gaps, output stalls and a long
// output hold-off.
// ----------------------------------------------------------------------------
module point_map_occupancy_statistics_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pmos_pkg::*;

    localparam t_coord ONE       = 32'sd65536;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam t_coord COORD_MAX = 32'sh7fff_ffff;
    localparam int     SPAN      = 50 * 65536;

    // Q4.12 levels: 0.6, 0.4 and the 0.19 intensity band
    localparam t_value OCC_LEVEL  = 16'sd2458;
    localparam t_value FREE_LEVEL = 16'sd1638;
    localparam t_value BAND_EDGE  = 16'sd778;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        t_value value;
        logic   first;
        logic   last;
    } t_map_point;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    pmos_point_if pt_if();
    pmos_stats_if st_if();

    point_map_occupancy_statistics dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_if),
        .o_st       (st_if)
    );

    // predictor state and its copy of the registers
    t_count free_cnt   = '0;
    t_count occ_cnt    = '0;
    t_count unseen_cnt = '0;
    t_coord lo_corner[3] = '{0, 0, 0};
    t_coord hi_corner[3] = '{0, 0, 0};
    logic   cfg_box_on = 1'b0;
    t_mode  cfg_mode   = MODE_OCTREE;
    t_coord cfg_lo[3]  = '{0, 0, 0};
    t_coord cfg_hi[3]  = '{0, 0, 0};

    t_stats pending_stats[$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_off      = 0;
    int mismatches    = 0;
    int beats_checked = 0;
    int points_sent   = 0;
    int random_points = 0;
    int settings_used = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d statistics beats outstanding", pending_stats.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic t_class classify_value(input t_value v);
        if (cfg_mode == MODE_OCTREE) begin
            if (v >= OCC_LEVEL)
                return CLS_OCC;
            if (v <= FREE_LEVEL)
                return CLS_FREE;
            return CLS_UNSEEN;
        end
        if (v >= -BAND_EDGE && v <= BAND_EDGE)
            return CLS_OCC;
        if (v > BAND_EDGE)
            return CLS_FREE;
        return CLS_NONE;
    endfunction

    function automatic void accumulate_point(input t_map_point p);
        t_coord c[3];
        logic   in_box;
        t_stats s;
        c[0] = p.x;
        c[1] = p.y;
        c[2] = p.z;
        if (p.first) begin
            free_cnt   = '0;
            occ_cnt    = '0;
            unseen_cnt = '0;
            for (int i = 0; i < 3; i++) begin
                lo_corner[i] = c[i];
                hi_corner[i] = c[i];
            end
        end
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (c[i] < lo_corner[i])
                lo_corner[i] = c[i];
            if (c[i] > hi_corner[i])
                hi_corner[i] = c[i];
            if (cfg_box_on && (c[i] < cfg_lo[i] || c[i] > cfg_hi[i]))
                in_box = 1'b0;
        end
        if (in_box) begin
            case (classify_value(p.value))
                CLS_FREE:   if (free_cnt != '1) free_cnt++;
                CLS_OCC:    if (occ_cnt != '1) occ_cnt++;
                CLS_UNSEEN: if (unseen_cnt != '1) unseen_cnt++;
                default: ;
            endcase
        end
        if (p.last) begin
            s.free_total     = free_cnt;
            s.occupied_total = occ_cnt;
            s.unseen_total   = unseen_cnt;
            s.min_x = lo_corner[0];
            s.max_x = hi_corner[0];
            s.min_y = lo_corner[1];
            s.max_y = hi_corner[1];
            s.min_z = lo_corner[2];
            s.max_z = hi_corner[2];
            pending_stats = {pending_stats, s};
        end
    endfunction

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%08h actual 0x%08h",
                     $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        t_stats want;
        if (rst_n && st_if.valid && st_if.ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t ns: stats beat with nothing expected, expected none actual free=%0d",
                         $time, st_if.free_total);
                mismatches++;
            end else begin
                want = pending_stats.pop_front();
                check_field("free_total", want.free_total, st_if.free_total);
                check_field("occupied_total", want.occupied_total, st_if.occupied_total);
                check_field("unseen_total", want.unseen_total, st_if.unseen_total);
                check_field("min_x", want.min_x, st_if.min_x);
                check_field("max_x", want.max_x, st_if.max_x);
                check_field("min_y", want.min_y, st_if.min_y);
                check_field("max_y", want.max_y, st_if.max_y);
                check_field("min_z", want.min_z, st_if.min_z);
                check_field("max_z", want.max_z, st_if.max_z);
                beats_checked++;
            end
        end
    end

    // output side: random stalls, plus a counted hold-off when requested
    initial begin
        st_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                st_if.ready <= 1'b0;
                hold_off--;
            end else begin
                st_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------
    task automatic offer_point(input t_map_point p);
        while ($urandom_range(99) < idle_pct) begin
            pt_if.valid <= 1'b0;
            @(negedge clk);
        end
        pt_if.valid       <= 1'b1;
        pt_if.point_x     <= p.x;
        pt_if.point_y     <= p.y;
        pt_if.point_z     <= p.z;
        pt_if.point_value <= p.value;
        pt_if.first_point <= p.first;
        pt_if.last_point  <= p.last;
        do @(posedge clk); while (pt_if.ready !== 1'b1);
        accumulate_point(p);
        points_sent++;
        @(negedge clk);
    endtask

    // stop offering and let every expected beat and any trailing point clear
    task automatic drain_stats();
        pt_if.valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BOX_ENABLE:  cfg_box_on = data[0];
            CFG_SOURCE_MODE: cfg_mode   = t_mode'(data[0]);
            CFG_BOX_X_LOW:   cfg_lo[0]  = t_coord'(data);
            CFG_BOX_X_HIGH:  cfg_hi[0]  = t_coord'(data);
            CFG_BOX_Y_LOW:   cfg_lo[1]  = t_coord'(data);
            CFG_BOX_Y_HIGH:  cfg_hi[1]  = t_coord'(data);
            CFG_BOX_Z_LOW:   cfg_lo[2]  = t_coord'(data);
            CFG_BOX_Z_HIGH:  cfg_hi[2]  = t_coord'(data);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_box(input logic on, input t_mode m, input t_coord xl, input t_coord xh,
                           input t_coord yl, input t_coord yh, input t_coord zl,
                           input t_coord zh);
        write_reg(CFG_BOX_ENABLE, t_cfg_data'(on));
        write_reg(CFG_SOURCE_MODE, t_cfg_data'(m));
        write_reg(CFG_BOX_X_LOW, t_cfg_data'(xl));
        write_reg(CFG_BOX_X_HIGH, t_cfg_data'(xh));
        write_reg(CFG_BOX_Y_LOW, t_cfg_data'(yl));
        write_reg(CFG_BOX_Y_HIGH, t_cfg_data'(yh));
        write_reg(CFG_BOX_Z_LOW, t_cfg_data'(zl));
        write_reg(CFG_BOX_Z_HIGH, t_cfg_data'(zh));
        settings_used++;
    endtask

    function automatic t_map_point mk_point(input t_coord x, input t_coord y, input t_coord z,
                                            input t_value v, input logic first,
                                            input logic last);
        t_map_point p;
        p.x     = x;
        p.y     = y;
        p.z     = z;
        p.value = v;
        p.first = first;
        p.last  = last;
        return p;
    endfunction

    function automatic t_coord random_coord();
        case ($urandom_range(5))
            0:       return t_coord'($urandom);
            1:       return $urandom_range(1) ? COORD_MAX : COORD_MIN;
            default: return t_coord'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
        endcase
    endfunction

    function automatic t_value random_value();
        t_value base;
        case ($urandom_range(3))
            0: return t_value'($urandom);
            1: begin
                case ($urandom_range(3))
                    0:       base = OCC_LEVEL;
                    1:       base = FREE_LEVEL;
                    2:       base = BAND_EDGE;
                    default: base = -BAND_EDGE;
                endcase
                return base + t_value'(int'($urandom_range(2)) - 1);
            end
            default: return t_value'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic t_map_point random_point();
        return mk_point(random_coord(), random_coord(), random_coord(), random_value(),
                        1'b0, 1'b0);
    endfunction

    // mostly well-formed maps; one in eight carries random first/last flags
    task automatic send_random_map();
        int         len;
        bit         noisy;
        t_map_point p;
        len   = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        noisy = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++) begin
            p = random_point();
            if (noisy) begin
                p.first = ($urandom_range(3) == 0);
                p.last  = ($urandom_range(3) == 0);
            end else begin
                p.first = (i == 0);
                p.last  = (i == len - 1);
            end
            offer_point(p);
            random_points++;
        end
    endtask

    // box kinds in turn: off, full range, empty, random; mode flips halfway
    task automatic random_setting(input int k);
        t_coord lo[3];
        t_coord hi[3];
        int     ax;
        for (int i = 0; i < 3; i++) begin
            lo[i] = t_coord'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
            hi[i] = lo[i] + t_coord'($urandom_range(0, 40 * 65536));
        end
        if (k % 4 == 1) begin
            for (int i = 0; i < 3; i++) begin
                lo[i] = COORD_MIN;
                hi[i] = COORD_MAX;
            end
        end else if (k % 4 == 2) begin
            ax     = $urandom_range(2);
            lo[ax] = hi[ax] + ONE;
        end
        set_box(k % 4 != 0, t_mode'((k / 4) % 2), lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // no first point yet: limits still include the reset origin
    task automatic test_reset_limits();
        offer_point(mk_point(5 * ONE, -3 * ONE, 7 * ONE, 16'sd0, 1'b0, 1'b0));
        offer_point(mk_point(2 * ONE, 4 * ONE, -ONE, 16'sd2458, 1'b0, 1'b0));
        offer_point(mk_point(ONE, ONE, ONE, 16'sd2000, 1'b0, 1'b1));
        drain_stats();
    endtask

    task automatic test_octree_thresholds();
        set_box(1'b0, MODE_OCTREE, 0, 0, 0, 0, 0, 0);
        offer_point(mk_point(COORD_MIN, COORD_MAX, 0, 16'sh8000, 1'b1, 1'b0));
        offer_point(mk_point(ONE, ONE, ONE, 16'sd1638, 1'b0, 1'b0));
        offer_point(mk_point(ONE, ONE, ONE, 16'sd1639, 1'b0, 1'b0));
        offer_point(mk_point(ONE, ONE, ONE, 16'sd2457, 1'b0, 1'b0));
        offer_point(mk_point(ONE, ONE, ONE, 16'sd2458, 1'b0, 1'b0));
        offer_point(mk_point(COORD_MAX, COORD_MIN, COORD_MIN, 16'sh7fff, 1'b0, 1'b1));
        drain_stats();
    endtask

    task automatic test_cloud_band();
        set_box(1'b0, MODE_CLOUD, 0, 0, 0, 0, 0, 0);
        offer_point(mk_point(-ONE, 2 * ONE, COORD_MAX, 16'sh8000, 1'b1, 1'b0));
        offer_point(mk_point(0, 0, 0, -16'sd779, 1'b0, 1'b0));
        offer_point(mk_point(0, 0, 0, -16'sd778, 1'b0, 1'b0));
        offer_point(mk_point(0, 0, 0, 16'sd778, 1'b0, 1'b0));
        offer_point(mk_point(0, 0, 0, 16'sd779, 1'b0, 1'b0));
        offer_point(mk_point(3 * ONE, -ONE, 0, 16'sh7fff, 1'b0, 1'b1));
        drain_stats();
    endtask

    // inclusive edges, one LSB outside on either side
    task automatic test_box_bounds();
        set_box(1'b1, MODE_OCTREE, -2 * ONE, 2 * ONE, -ONE, ONE, 0, 3 * ONE);
        offer_point(mk_point(-2 * ONE, -ONE, 0, 16'sd0, 1'b1, 1'b0));
        offer_point(mk_point(2 * ONE, ONE, 3 * ONE, 16'sd3000, 1'b0, 1'b0));
        offer_point(mk_point(2 * ONE + 1, 0, ONE, 16'sd0, 1'b0, 1'b0));
        offer_point(mk_point(0, 0, -1, 16'sd0, 1'b0, 1'b0));
        offer_point(mk_point(0, ONE / 2, ONE, 16'sd2000, 1'b0, 1'b1));
        drain_stats();
    endtask

    task automatic test_empty_box();
        set_box(1'b1, MODE_CLOUD, ONE, -ONE, -ONE, ONE, -ONE, ONE);
        offer_point(mk_point(0, 0, 0, 16'sd0, 1'b1, 1'b0));
        offer_point(mk_point(ONE, -ONE, 0, 16'sd1000, 1'b0, 1'b1));
        drain_stats();
    endtask

    // one-point map, then a later point that keeps adding to it
    task automatic test_single_point_maps();
        set_box(1'b0, MODE_OCTREE, 0, 0, 0, 0, 0, 0);
        offer_point(mk_point(-7 * ONE, 9 * ONE, -ONE, 16'sd1000, 1'b1, 1'b1));
        offer_point(mk_point(4 * ONE, -2 * ONE, 6 * ONE, 16'sd2500, 1'b0, 1'b1));
        drain_stats();
    endtask

    task automatic test_random_maps();
        int idle_set[4]  = '{0, 84, 0, 6};
        int stall_set[4] = '{0, 0, 84, 6};
        int phase_target;
        for (int k = 0; k < 8; k++) begin
            drain_stats();
            random_setting(k);
            idle_pct     = idle_set[k / 2];
            stall_pct    = stall_set[k / 2];
            phase_target = random_points + 150;
            while (random_points < phase_target)
                send_random_map();
        end
        drain_stats();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // o_st held off while two-point maps keep arriving: the input must stall
    task automatic test_backpressure();
        t_map_point p;
        idle_pct  = 0;
        stall_pct = 0;
        hold_off  = 200;
        for (int i = 0; i < 16; i++) begin
            p       = random_point();
            p.first = 1'b1;
            offer_point(p);
            p      = random_point();
            p.last = 1'b1;
            offer_point(p);
        end
        drain_stats();
    endtask

    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_BOX_ENABLE;
        cfg_data          = '0;
        pt_if.valid       = 1'b0;
        pt_if.point_x     = '0;
        pt_if.point_y     = '0;
        pt_if.point_z     = '0;
        pt_if.point_value = '0;
        pt_if.first_point = 1'b0;
        pt_if.last_point  = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_limits();
        test_octree_thresholds();
        test_cloud_band();
        test_box_bounds();
        test_empty_box();
        test_single_point_maps();
        test_random_maps();
        test_backpressure();
        drain_stats();

        $display("Checked %0d stats beats from %0d points (%0d random) over %0d box settings",
                 beats_checked, points_sent, random_points, settings_used);
        $display("Both modes, box off/full/empty/random, input gaps, output stalls, hold-off");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/pmos_pkg.sv
design/pmos_point_if.sv
design/pmos_stats_if.sv
design/pmos_classify.sv
design/pmos_accum.sv
design/point_map_occupancy_statistics.sv
dv/point_map_occupancy_statistics_test.sv
